// ===== rtl/core/srs_pkg.sv =====
// Shared types and constants for the selective-repeat sender window.
// Used by srs_front, srs_back and the top level; no dependencies.
package srs_pkg;

   localparam int SEQ_FIELD_W = 11;
   localparam int WINDOW_W    = 6;
   localparam int TIMER_W     = 16;
   localparam int CSR_ADDR_W  = 4;
   localparam int CSR_DATA_W  = 32;
   localparam int CMD_DEPTH   = 4;
   localparam int RSP_DEPTH   = 4;

   localparam logic [1:0] REG_WINDOW_SIZE   = 2'd0;
   localparam logic [1:0] REG_PACKET_COUNT  = 2'd1;
   localparam logic [1:0] REG_TIMEOUT_TICKS = 2'd2;

   localparam logic [WINDOW_W-1:0]    RST_WINDOW_SIZE   = 6'd4;
   localparam logic [SEQ_FIELD_W-1:0] RST_PACKET_COUNT  = 11'd1;
   localparam logic [TIMER_W-1:0]     RST_TIMEOUT_TICKS = 16'd500;

   localparam logic FUNC_TICK = 1'b0;
   localparam logic FUNC_ACK  = 1'b1;

   localparam logic [1:0] CMD_TICK = 2'd0;
   localparam logic [1:0] CMD_ACK  = 2'd1;
   localparam logic [1:0] CMD_NOP  = 2'd2;

   typedef struct packed {
      logic [WINDOW_W-1:0]    window_size;
      logic [SEQ_FIELD_W-1:0] packet_count;
      logic [TIMER_W-1:0]     timeout_ticks;
   } cfg_type;

   typedef struct packed {
      logic [1:0]             kind;
      logic [SEQ_FIELD_W-1:0] ack;
   } cmd_type;

   typedef struct packed {
      logic [SEQ_FIELD_W-1:0] send_seq;
      logic                   is_retransmit;
      logic                   is_end_of_file;
      logic                   transfer_done;
      logic                   last_of_run;
   } rsp_type;

endpackage

// ===== rtl/core/srs_fifo.sv =====
// Small first-in first-out queue of flat words.
// Generic; used for the command queue and the result queue.
module srs_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wr_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rd_data,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]   count_ff, count_in;
   logic             do_wr, do_rd;

   assign full    = (count_ff == (PTR_W+1)'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_wr   = push && !full;
   assign do_rd   = pop && !empty;
   assign rd_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         slot_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

// ===== rtl/core/srs_front.sv =====
// Front end: configuration registers and classification of incoming events.
// Depends on srs_pkg.
module srs_front #(
   parameter int MAX_PACKETS = 1024
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [srs_pkg::CSR_ADDR_W-1:0]      paddr,
   input  logic [srs_pkg::CSR_DATA_W-1:0]      pwdata,
   output logic [srs_pkg::CSR_DATA_W-1:0]      prdata,
   input  logic                                req_func,
   input  logic [srs_pkg::SEQ_FIELD_W-1:0]     req_ack_number,
   input  logic                                req_ack_valid,
   output srs_pkg::cfg_type                    cfg,
   output srs_pkg::cmd_type                    cmd
);

   localparam int CAP = (MAX_PACKETS < 2047) ? MAX_PACKETS : 2047;

   logic [srs_pkg::WINDOW_W-1:0]    window_ff, window_in;
   logic [srs_pkg::SEQ_FIELD_W-1:0] count_ff, count_in;
   logic [srs_pkg::TIMER_W-1:0]     timeout_ff, timeout_in;
   logic [1:0]                      reg_idx;
   logic                            csr_wr;
   logic                            ack_ok;

   assign reg_idx = paddr[srs_pkg::CSR_ADDR_W-1:2];
   assign csr_wr  = psel && penable && pwrite;

   always_comb begin
      window_in  = window_ff;
      count_in   = count_ff;
      timeout_in = timeout_ff;
      if (csr_wr) begin
         case (reg_idx)
            srs_pkg::REG_WINDOW_SIZE:   window_in  = pwdata[srs_pkg::WINDOW_W-1:0];
            srs_pkg::REG_PACKET_COUNT:  count_in   = pwdata[srs_pkg::SEQ_FIELD_W-1:0];
            srs_pkg::REG_TIMEOUT_TICKS: timeout_in = pwdata[srs_pkg::TIMER_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff  <= srs_pkg::RST_WINDOW_SIZE;
         count_ff   <= srs_pkg::RST_PACKET_COUNT;
         timeout_ff <= srs_pkg::RST_TIMEOUT_TICKS;
      end else begin
         window_ff  <= window_in;
         count_ff   <= count_in;
         timeout_ff <= timeout_in;
      end
   end

   always_comb begin
      case (reg_idx)
         srs_pkg::REG_WINDOW_SIZE:   prdata = srs_pkg::CSR_DATA_W'(window_ff);
         srs_pkg::REG_PACKET_COUNT:  prdata = srs_pkg::CSR_DATA_W'(count_ff);
         srs_pkg::REG_TIMEOUT_TICKS: prdata = srs_pkg::CSR_DATA_W'(timeout_ff);
         default:                    prdata = '0;
      endcase
   end

   assign cfg.window_size   = window_ff;
   assign cfg.packet_count  = count_ff;
   assign cfg.timeout_ticks = timeout_ff;

   // drop acks that are bad, zero, or past the last packet
   assign ack_ok = req_ack_valid && (req_ack_number != '0) &&
                   (req_ack_number <= count_ff) &&
                   (12'(req_ack_number) <= 12'(CAP));

   always_comb begin
      cmd.ack = req_ack_number;
      if (req_func == srs_pkg::FUNC_TICK) begin
         cmd.kind = srs_pkg::CMD_TICK;
      end else if (ack_ok) begin
         cmd.kind = srs_pkg::CMD_ACK;
      end else begin
         cmd.kind = srs_pkg::CMD_NOP;
      end
   end

endmodule

// ===== rtl/core/srs_back.sv =====
// Back end: window state, acknowledged-bit memory and result sequencer.
// Depends on srs_pkg; takes commands from and gives results to srs_fifo queues.
module srs_back #(
   parameter int MAX_PACKETS = 1024,
   parameter int MAX_WINDOW  = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  srs_pkg::cfg_type cfg,
   input  srs_pkg::cmd_type cmd,
   input  logic             cmd_empty,
   output logic             cmd_pop,
   output srs_pkg::rsp_type rsp,
   input  logic             rsp_full,
   output logic             rsp_push,
   output logic             clearing
);

   localparam int CAP    = (MAX_PACKETS < 2047) ? MAX_PACKETS : 2047;
   localparam int SEQ_W  = $clog2(CAP + 2);
   localparam int ADDR_W = $clog2(CAP + 1);
   localparam int WIN_W  = $clog2(MAX_WINDOW + 1);
   localparam int SUM_W  = ((SEQ_W > WIN_W) ? SEQ_W : WIN_W) + 1;
   localparam int SEQ_FW = srs_pkg::SEQ_FIELD_W;

   localparam logic [3:0] ST_CLEAR     = 4'd0;
   localparam logic [3:0] ST_IDLE      = 4'd1;
   localparam logic [3:0] ST_SLIDE_RD  = 4'd2;
   localparam logic [3:0] ST_SLIDE_CHK = 4'd3;
   localparam logic [3:0] ST_SEND      = 4'd4;
   localparam logic [3:0] ST_TIMER     = 4'd5;
   localparam logic [3:0] ST_RTX_RD    = 4'd6;
   localparam logic [3:0] ST_RTX_CHK   = 4'd7;
   localparam logic [3:0] ST_FINISH    = 4'd8;

   logic                        acked_mem [CAP + 1];
   logic                        rd_ff;

   logic [3:0]                  state_ff, state_in;
   logic [SEQ_W-1:0]            base_ff, base_in;
   logic [SEQ_W-1:0]            hs_ff, hs_in;
   logic [SEQ_W-1:0]            idx_ff, idx_in;
   logic [srs_pkg::TIMER_W-1:0] timer_ff, timer_in;
   srs_pkg::rsp_type            pend_ff, pend_in;
   logic                        pend_valid_ff, pend_valid_in;

   logic                        mem_we, mem_wdata, mem_re;
   logic [ADDR_W-1:0]           mem_waddr, mem_raddr;

   logic [SEQ_W-1:0]            pc_eff;
   logic [WIN_W-1:0]            win;
   logic [SEQ_W-1:0]            cand;
   logic [SEQ_W-1:0]            ack_s;
   logic                        done;
   logic                        can_take;
   logic                        fits;

   function automatic srs_pkg::rsp_type make_rsp(input logic [SEQ_FW-1:0] seq,
                                                 input logic retx, input logic eof,
                                                 input logic fin, input logic last);
      srs_pkg::rsp_type r;
      r.send_seq       = seq;
      r.is_retransmit  = retx;
      r.is_end_of_file = eof;
      r.transfer_done  = fin;
      r.last_of_run    = last;
      return r;
   endfunction

   assign pc_eff = ({1'b0, cfg.packet_count} > 12'(CAP)) ? SEQ_W'(CAP)
                                                           : SEQ_W'(cfg.packet_count);
   assign win    = (cfg.window_size > srs_pkg::WINDOW_W'(MAX_WINDOW)) ? WIN_W'(MAX_WINDOW)
                                                                       : WIN_W'(cfg.window_size);
   assign cand     = hs_ff + 1'b1;
   assign ack_s    = SEQ_W'(cmd.ack);
   assign done     = (base_ff > pc_eff);
   assign can_take = !pend_valid_ff || !rsp_full;
   assign fits     = (SUM_W'(cand) < (SUM_W'(base_ff) + SUM_W'(win))) && (cand <= pc_eff);
   assign clearing = (state_ff == ST_CLEAR);

   always_comb begin
      state_in      = state_ff;
      base_in       = base_ff;
      hs_in         = hs_ff;
      idx_in        = idx_ff;
      timer_in      = timer_ff;
      pend_in       = pend_ff;
      pend_valid_in = pend_valid_ff;
      cmd_pop       = 1'b0;
      rsp_push      = 1'b0;
      rsp           = make_rsp('0, 1'b0, 1'b0, done, 1'b0);
      mem_we        = 1'b0;
      mem_wdata     = 1'b0;
      mem_waddr     = idx_ff[ADDR_W-1:0];
      mem_re        = 1'b0;
      mem_raddr     = idx_ff[ADDR_W-1:0];
      case (state_ff)
         ST_CLEAR: begin
            mem_we = 1'b1;
            if (idx_ff == SEQ_W'(CAP)) begin
               idx_in   = '0;
               state_in = ST_IDLE;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            if (!cmd_empty) begin
               cmd_pop = 1'b1;
               case (cmd.kind)
                  srs_pkg::CMD_TICK: state_in = ST_SEND;
                  srs_pkg::CMD_ACK: begin
                     state_in = ST_FINISH;
                     if (ack_s >= base_ff) begin
                        mem_we    = 1'b1;
                        mem_wdata = 1'b1;
                        mem_waddr = ack_s[ADDR_W-1:0];
                        if (base_ff != cand) begin
                           timer_in = '0;
                           state_in = ST_SLIDE_RD;
                        end
                     end
                  end
                  default: state_in = ST_FINISH;
               endcase
            end
         end
         ST_SLIDE_RD: begin
            if (base_ff <= pc_eff) begin
               mem_re    = 1'b1;
               mem_raddr = base_ff[ADDR_W-1:0];
               state_in  = ST_SLIDE_CHK;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_SLIDE_CHK: begin
            if (rd_ff) begin
               base_in  = base_ff + 1'b1;
               timer_in = '0;
               state_in = ST_SLIDE_RD;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_SEND: begin
            if (fits) begin
               if (can_take) begin
                  if (pend_valid_ff) begin
                     rsp_push = 1'b1;
                     rsp      = make_rsp(pend_ff.send_seq, pend_ff.is_retransmit,
                                         pend_ff.is_end_of_file, done, 1'b0);
                  end
                  pend_in       = make_rsp(SEQ_FW'(cand), 1'b0, cand == pc_eff, 1'b0, 1'b0);
                  pend_valid_in = 1'b1;
                  hs_in         = cand;
                  if (base_ff == cand) begin
                     timer_in = '0;
                  end
               end
            end else begin
               state_in = ST_TIMER;
            end
         end
         ST_TIMER: begin
            state_in = ST_FINISH;
            if (base_ff <= pc_eff) begin
               if (timer_ff >= cfg.timeout_ticks) begin
                  timer_in = '0;
                  idx_in   = base_ff;
                  state_in = ST_RTX_RD;
               end else begin
                  timer_in = timer_ff + 1'b1;
               end
            end
         end
         ST_RTX_RD: begin
            if ((idx_ff <= hs_ff) && (idx_ff <= pc_eff)) begin
               mem_re    = 1'b1;
               mem_raddr = idx_ff[ADDR_W-1:0];
               state_in  = ST_RTX_CHK;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_RTX_CHK: begin
            if (rd_ff) begin
               idx_in   = idx_ff + 1'b1;
               state_in = ST_RTX_RD;
            end else if (can_take) begin
               if (pend_valid_ff) begin
                  rsp_push = 1'b1;
                  rsp      = make_rsp(pend_ff.send_seq, pend_ff.is_retransmit,
                                      pend_ff.is_end_of_file, done, 1'b0);
               end
               pend_in       = make_rsp(SEQ_FW'(idx_ff), 1'b1, idx_ff == pc_eff, 1'b0, 1'b0);
               pend_valid_in = 1'b1;
               idx_in        = idx_ff + 1'b1;
               state_in      = ST_RTX_RD;
            end
         end
         ST_FINISH: begin
            if (!rsp_full) begin
               rsp_push = 1'b1;
               if (pend_valid_ff) begin
                  rsp = make_rsp(pend_ff.send_seq, pend_ff.is_retransmit,
                                 pend_ff.is_end_of_file, done, 1'b1);
               end else begin
                  rsp = make_rsp('0, 1'b0, 1'b0, done, 1'b1);
               end
               pend_valid_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         base_ff       <= SEQ_W'(1);
         hs_ff         <= '0;
         idx_ff        <= '0;
         timer_ff      <= '0;
         pend_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         base_ff       <= base_in;
         hs_ff         <= hs_in;
         idx_ff        <= idx_in;
         timer_ff      <= timer_in;
         pend_valid_ff <= pend_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_ff <= pend_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         acked_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_ff <= acked_mem[mem_raddr];
      end
   end

endmodule

// ===== rtl/core/selective_repeat_sender_window.sv =====
// Selective-repeat ARQ sender window. After reset a clearing pass zeroes every entry
// of the acknowledged-bit memory; full stays high meanwhile. A tick sends each new
// packet that fits the window, then checks the timer and on timeout scans the window
// entries for retransmission. An ack marks its packet and, where it can, slides the
// base past acknowledged packets. The scan loops read the acknowledged-bit memory one
// entry at a time through its single read port; a full result queue stalls sending,
// retransmission and the final result.
// Depends on srs_pkg, srs_front, srs_back and srs_fifo.
module selective_repeat_sender_window #(
   parameter int MAX_PACKETS = 1024,
   parameter int MAX_WINDOW  = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [srs_pkg::CSR_ADDR_W-1:0]      paddr,
   input  logic [srs_pkg::CSR_DATA_W-1:0]      pwdata,
   output logic [srs_pkg::CSR_DATA_W-1:0]      prdata,
   output logic                                pready,
   input  logic                                push,
   output logic                                full,
   input  logic                                req_func,
   input  logic [srs_pkg::SEQ_FIELD_W-1:0]     req_ack_number,
   input  logic                                req_ack_valid,
   output logic                                empty,
   input  logic                                pop,
   output logic [srs_pkg::SEQ_FIELD_W-1:0]     rsp_send_seq,
   output logic                                rsp_is_retransmit,
   output logic                                rsp_is_end_of_file,
   output logic                                rsp_transfer_done,
   output logic                                rsp_last_of_run
);

   srs_pkg::cfg_type cfg;
   srs_pkg::cmd_type cmd_in, cmd_out;
   srs_pkg::rsp_type rsp_in, rsp_out;
   logic             cmd_full, cmd_empty, cmd_pop;
   logic             rsp_full, rsp_push;
   logic             clearing;

   assign pready = 1'b1;
   assign full   = cmd_full || clearing;

   srs_front #(
      .MAX_PACKETS (MAX_PACKETS)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .req_func       (req_func),
      .req_ack_number (req_ack_number),
      .req_ack_valid  (req_ack_valid),
      .cfg            (cfg),
      .cmd            (cmd_in)
   );

   srs_fifo #(
      .WIDTH ($bits(srs_pkg::cmd_type)),
      .DEPTH (srs_pkg::CMD_DEPTH)
   ) u_cmd_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push && !full),
      .wr_data (cmd_in),
      .full    (cmd_full),
      .pop     (cmd_pop),
      .rd_data (cmd_out),
      .empty   (cmd_empty)
   );

   srs_back #(
      .MAX_PACKETS (MAX_PACKETS),
      .MAX_WINDOW  (MAX_WINDOW)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .cmd       (cmd_out),
      .cmd_empty (cmd_empty),
      .cmd_pop   (cmd_pop),
      .rsp       (rsp_in),
      .rsp_full  (rsp_full),
      .rsp_push  (rsp_push),
      .clearing  (clearing)
   );

   srs_fifo #(
      .WIDTH ($bits(srs_pkg::rsp_type)),
      .DEPTH (srs_pkg::RSP_DEPTH)
   ) u_rsp_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (rsp_push),
      .wr_data (rsp_in),
      .full    (rsp_full),
      .pop     (pop),
      .rd_data (rsp_out),
      .empty   (empty)
   );

   assign rsp_send_seq       = rsp_out.send_seq;
   assign rsp_is_retransmit  = rsp_out.is_retransmit;
   assign rsp_is_end_of_file = rsp_out.is_end_of_file;
   assign rsp_transfer_done  = rsp_out.transfer_done;
   assign rsp_last_of_run    = rsp_out.last_of_run;

endmodule

// ===== test/srs_window_checker.sv =====
`timescale 1ns / 100ps
// Checker for the selective-repeat sender window: snoops register writes, accepted
// events and popped send orders, predicts each order and compares them in sequence.
// Depends on srs_pkg only.
module srs_window_checker
   import srs_pkg::*;
#(
   parameter int MAX_PACKETS = 1024,
   parameter int MAX_WINDOW  = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   psel,
   input  logic                   penable,
   input  logic                   pwrite,
   input  logic [CSR_ADDR_W-1:0]  paddr,
   input  logic [CSR_DATA_W-1:0]  pwdata,
   input  logic                   pready,
   input  logic                   push,
   input  logic                   full,
   input  logic                   req_func,
   input  logic [SEQ_FIELD_W-1:0] req_ack_number,
   input  logic                   req_ack_valid,
   input  logic                   empty,
   input  logic                   pop,
   input  logic [SEQ_FIELD_W-1:0] rsp_send_seq,
   input  logic                   rsp_is_retransmit,
   input  logic                   rsp_is_end_of_file,
   input  logic                   rsp_transfer_done,
   input  logic                   rsp_last_of_run,
   output int                     fail_count,
   output int                     outstanding
);

   localparam int MAX_RUN      = 64;
   localparam int REPORT_LIMIT = 10;

   logic [WINDOW_W-1:0]    cfg_window;
   logic [SEQ_FIELD_W-1:0] cfg_packets;
   logic [TIMER_W-1:0]     cfg_timeout;

   logic [SEQ_FIELD_W-1:0] win_base;
   logic [SEQ_FIELD_W-1:0] sent_high;
   logic [TIMER_W-1:0]     idle_ticks;
   bit                     acked_seq [0:MAX_PACKETS];

   rsp_type expected_sends[$];
   int      errors = 0;

   function automatic rsp_type send_order(input int unsigned seq, input logic retx,
                                          input logic eof);
      rsp_type order;
      order = '0;
      order.send_seq       = SEQ_FIELD_W'(seq);
      order.is_retransmit  = retx;
      order.is_end_of_file = eof;
      return order;
   endfunction

   task automatic predict_sends(input logic func, input logic [SEQ_FIELD_W-1:0] ack_no,
                                input logic ack_ok);
      int unsigned pc;
      int unsigned win;
      int unsigned lim;
      int unsigned seq;
      int unsigned base;
      int unsigned sent;
      rsp_type     run_q[$];
      rsp_type     order;
      base = win_base;
      sent = sent_high;
      pc   = (cfg_packets > MAX_PACKETS) ? MAX_PACKETS : cfg_packets;
      if (func == FUNC_ACK) begin
         if (ack_ok && ack_no >= base && ack_no <= pc) begin
            acked_seq[ack_no] = 1'b1;
            if (base != sent + 1) begin
               idle_ticks = '0;
               while (base <= pc && acked_seq[base]) begin
                  base++;
                  idle_ticks = '0;
               end
            end
         end
      end else begin
         win = (cfg_window > MAX_WINDOW) ? MAX_WINDOW : cfg_window;
         lim = base + win;
         if (lim > pc + 1)
            lim = pc + 1;
         for (seq = sent + 1; seq < lim && run_q.size() < MAX_RUN; seq++) begin
            run_q.push_back(send_order(seq, 1'b0, seq == pc));
            sent = seq;
            if (base == sent)
               idle_ticks = '0;
         end
         if (base <= pc) begin
            if (idle_ticks >= cfg_timeout) begin
               idle_ticks = '0;
               for (seq = base; seq <= sent && seq <= pc && run_q.size() < MAX_RUN; seq++) begin
                  if (!acked_seq[seq])
                     run_q.push_back(send_order(seq, 1'b1, seq == pc));
               end
            end else begin
               idle_ticks = idle_ticks + 1'b1;
            end
         end
      end
      if (run_q.size() == 0)
         run_q.push_back(send_order(0, 1'b0, 1'b0));
      foreach (run_q[k]) begin
         order = run_q[k];
         order.transfer_done = (base > pc);
         order.last_of_run   = (k == run_q.size() - 1);
         expected_sends.push_back(order);
      end
      win_base  = SEQ_FIELD_W'(base);
      sent_high = SEQ_FIELD_W'(sent);
   endtask

   task automatic check_send;
      rsp_type want;
      if (expected_sends.size() == 0) begin
         errors++;
         if (errors <= REPORT_LIMIT)
            $display("unexpected send order: seq %0d retx %0b eof %0b done %0b last %0b",
                     rsp_send_seq, rsp_is_retransmit, rsp_is_end_of_file,
                     rsp_transfer_done, rsp_last_of_run);
      end else begin
         want = expected_sends.pop_front();
         if (rsp_send_seq !== want.send_seq || rsp_is_retransmit !== want.is_retransmit ||
             rsp_is_end_of_file !== want.is_end_of_file ||
             rsp_transfer_done !== want.transfer_done ||
             rsp_last_of_run !== want.last_of_run) begin
            errors++;
            if (errors <= REPORT_LIMIT)
               $display({"send order mismatch: expected seq %0d retx %0b eof %0b done %0b ",
                         "last %0b, got seq %0d retx %0b eof %0b done %0b last %0b"},
                        want.send_seq, want.is_retransmit, want.is_end_of_file,
                        want.transfer_done, want.last_of_run, rsp_send_seq,
                        rsp_is_retransmit, rsp_is_end_of_file, rsp_transfer_done,
                        rsp_last_of_run);
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         cfg_window  = RST_WINDOW_SIZE;
         cfg_packets = RST_PACKET_COUNT;
         cfg_timeout = RST_TIMEOUT_TICKS;
         win_base    = SEQ_FIELD_W'(1);
         sent_high   = '0;
         idle_ticks  = '0;
         foreach (acked_seq[i])
            acked_seq[i] = 1'b0;
         expected_sends.delete();
      end else begin
         if (psel && penable && pwrite && pready) begin
            case (paddr[CSR_ADDR_W-1:2])
               REG_WINDOW_SIZE:   cfg_window  = pwdata[WINDOW_W-1:0];
               REG_PACKET_COUNT:  cfg_packets = pwdata[SEQ_FIELD_W-1:0];
               REG_TIMEOUT_TICKS: cfg_timeout = pwdata[TIMER_W-1:0];
               default: ;
            endcase
         end
         if (push && !full)
            predict_sends(req_func, req_ack_number, req_ack_valid);
         if (pop && !empty)
            check_send();
      end
      fail_count  <= errors;
      outstanding <= expected_sends.size();
   end

endmodule

// ===== test/tb_selective_repeat_sender_window.sv =====
`timescale 1ns / 100ps
// Testbench top for selective_repeat_sender_window: drives ticks, acks and register
// writes with random idling and stalls, and reports the verdict of srs_window_checker.
// Depends on srs_pkg, the block under test and srs_window_checker.
module tb_selective_repeat_sender_window;
   import srs_pkg::*;

   localparam int MAX_PACKETS    = 1024;
   localparam int MAX_WINDOW     = 32;
   localparam int RESET_CYCLES   = 7;
   localparam int SETTLE_CYCLES  = 16;
   localparam int LONG_HOLD      = 400;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam logic [SEQ_FIELD_W-1:0] SEQ_MAX = '1;

   logic                   clock          = 1'b0;
   logic                   reset          = 1'b1;
   logic                   psel           = 1'b0;
   logic                   penable        = 1'b0;
   logic                   pwrite         = 1'b0;
   logic [CSR_ADDR_W-1:0]  paddr          = '0;
   logic [CSR_DATA_W-1:0]  pwdata         = '0;
   logic [CSR_DATA_W-1:0]  prdata;
   logic                   pready;
   logic                   push           = 1'b0;
   logic                   full;
   logic                   req_func       = FUNC_TICK;
   logic [SEQ_FIELD_W-1:0] req_ack_number = '0;
   logic                   req_ack_valid  = 1'b0;
   logic                   empty;
   logic                   pop            = 1'b0;
   logic [SEQ_FIELD_W-1:0] rsp_send_seq;
   logic                   rsp_is_retransmit;
   logic                   rsp_is_end_of_file;
   logic                   rsp_transfer_done;
   logic                   rsp_last_of_run;

   int                     fail_count;
   int                     outstanding;
   int                     send_idle_pct  = 37;
   int                     recv_idle_pct  = 83;
   int                     stall_asks     = 0;
   int                     stall_seen     = 0;
   int                     hold_left      = 0;
   int                     quiet_cycles   = 0;
   int                     ack_floor      = 1;
   logic [SEQ_FIELD_W-1:0] sent_top       = '0;

   selective_repeat_sender_window #(
      .MAX_PACKETS(MAX_PACKETS),
      .MAX_WINDOW (MAX_WINDOW)
   ) u_dut (
      .clock             (clock),
      .reset             (reset),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .prdata            (prdata),
      .pready            (pready),
      .push              (push),
      .full              (full),
      .req_func          (req_func),
      .req_ack_number    (req_ack_number),
      .req_ack_valid     (req_ack_valid),
      .empty             (empty),
      .pop               (pop),
      .rsp_send_seq      (rsp_send_seq),
      .rsp_is_retransmit (rsp_is_retransmit),
      .rsp_is_end_of_file(rsp_is_end_of_file),
      .rsp_transfer_done (rsp_transfer_done),
      .rsp_last_of_run   (rsp_last_of_run)
   );

   srs_window_checker #(
      .MAX_PACKETS(MAX_PACKETS),
      .MAX_WINDOW (MAX_WINDOW)
   ) u_checker (
      .clock             (clock),
      .reset             (reset),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .pready            (pready),
      .push              (push),
      .full              (full),
      .req_func          (req_func),
      .req_ack_number    (req_ack_number),
      .req_ack_valid     (req_ack_valid),
      .empty             (empty),
      .pop               (pop),
      .rsp_send_seq      (rsp_send_seq),
      .rsp_is_retransmit (rsp_is_retransmit),
      .rsp_is_end_of_file(rsp_is_end_of_file),
      .rsp_transfer_done (rsp_transfer_done),
      .rsp_last_of_run   (rsp_last_of_run),
      .fail_count        (fail_count),
      .outstanding       (outstanding)
   );

   always #10 clock = ~clock;

   // hold pop low for a long stretch on each new stall request
   always @(posedge clock) begin
      if (reset) begin
         pop <= 1'b0;
      end else if (stall_seen != stall_asks) begin
         stall_seen <= stall_asks;
         hold_left  <= LONG_HOLD;
         pop        <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         pop       <= 1'b0;
      end else begin
         pop <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (pop && !empty && !rsp_is_retransmit && rsp_send_seq > sent_top)
         sent_top <= rsp_send_seq;
   end

   always @(posedge clock) begin
      if (reset || (push && !full) || (pop && !empty)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("selective_repeat_sender_window test failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic offer(input logic func, input logic [SEQ_FIELD_W-1:0] num,
                        input logic ok);
      while ($urandom_range(99) < send_idle_pct) begin
         push <= 1'b0;
         @(posedge clock);
      end
      push           <= 1'b1;
      req_func       <= func;
      req_ack_number <= num;
      req_ack_valid  <= ok;
      @(posedge clock);
      while (full)
         @(posedge clock);
   endtask

   task automatic wait_for_results;
      push <= 1'b0;
      @(posedge clock);
      while (outstanding != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [1:0] index, input logic [CSR_DATA_W-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {index, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready)
         @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic write_registers(input int unsigned win, input int unsigned packets,
                                  input int unsigned ticks);
      write_register(REG_WINDOW_SIZE, CSR_DATA_W'(win));
      write_register(REG_PACKET_COUNT, CSR_DATA_W'(packets));
      write_register(REG_TIMEOUT_TICKS, CSR_DATA_W'(ticks));
   endtask

   // mostly ticks and acks of outstanding packets, in order or ahead of the floor up to the top sent
   task automatic offer_random;
      int unsigned            pick;
      int                     sent;
      logic [SEQ_FIELD_W-1:0] num;
      pick = $urandom_range(99);
      sent = sent_top;
      if (pick < 45) begin
         offer(FUNC_TICK, SEQ_FIELD_W'($urandom_range(SEQ_MAX)), 1'($urandom_range(1)));
      end else if (pick < 85) begin
         if (ack_floor > sent + 1) begin
            num = SEQ_FIELD_W'($urandom_range(sent + 1, 1));
         end else if (ack_floor > sent || $urandom_range(2) != 0) begin
            num = SEQ_FIELD_W'(ack_floor);
            ack_floor++;
         end else begin
            num = SEQ_FIELD_W'($urandom_range(sent, ack_floor + 1));
         end
         offer(FUNC_ACK, num, 1'b1);
      end else begin
         offer(1'($urandom_range(1)), SEQ_FIELD_W'($urandom_range(SEQ_MAX)),
               1'($urandom_range(1)));
      end
   endtask

   task automatic run_random(input int count);
      repeat (count) offer_random();
   endtask

   initial begin
      int unsigned finish_pc;
      int unsigned seq;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      while (full !== 1'b0)
         @(posedge clock);

      offer(FUNC_TICK, '0, 1'b0);
      offer(FUNC_ACK, SEQ_FIELD_W'(1), 1'b0);
      offer(FUNC_ACK, '0, 1'b1);
      offer(FUNC_ACK, SEQ_MAX, 1'b1);
      offer(FUNC_TICK, '0, 1'b0);

      wait_for_results();
      write_registers(0, 2047, 0);
      offer(FUNC_TICK, '0, 1'b0);
      offer(FUNC_ACK, SEQ_FIELD_W'(3), 1'b1);
      offer(FUNC_ACK, SEQ_FIELD_W'(1), 1'b1);
      offer(FUNC_TICK, SEQ_MAX, 1'b1);

      wait_for_results();
      write_registers(63, 2047, 65535);
      offer(FUNC_TICK, '0, 1'b0);
      offer(FUNC_ACK, SEQ_FIELD_W'(MAX_PACKETS), 1'b1);
      offer(FUNC_ACK, SEQ_FIELD_W'(2), 1'b1);
      offer(FUNC_TICK, '0, 1'b0);

      wait_for_results();
      write_registers(4, 0, 500);
      offer(FUNC_TICK, '0, 1'b0);
      offer(FUNC_ACK, SEQ_FIELD_W'(5), 1'b1);

      wait_for_results();
      write_registers(32, sent_top + 2, 1);
      repeat (3) offer(FUNC_TICK, '0, 1'b0);

      wait_for_results();
      write_registers(32, 2047, 3);
      run_random(70);

      wait_for_results();
      write_registers(1, MAX_PACKETS, 0);
      run_random(55);

      // finish the transfer: ack everything up to the last packet
      wait_for_results();
      finish_pc = (sent_top + 6 > MAX_PACKETS) ? MAX_PACKETS : sent_top + 6;
      write_registers($urandom_range(MAX_WINDOW, 1), finish_pc, $urandom_range(8, 2));
      run_random(25);
      for (seq = ack_floor; seq <= finish_pc; seq++)
         offer(FUNC_ACK, SEQ_FIELD_W'(seq), 1'b1);
      if (ack_floor <= finish_pc)
         ack_floor = finish_pc + 1;
      offer(FUNC_TICK, '0, 1'b0);
      offer(FUNC_ACK, SEQ_FIELD_W'(finish_pc), 1'b1);
      repeat (2) offer(FUNC_TICK, '0, 1'b0);

      send_idle_pct = 83;
      recv_idle_pct <= 37;
      wait_for_results();
      write_registers($urandom_range(MAX_WINDOW - 1, 2), 2047, 5);
      run_random(80);

      wait_for_results();
      write_registers(63, 2047, 0);
      run_random(40);

      send_idle_pct = 0;
      recv_idle_pct <= 0;
      wait_for_results();
      write_registers(32, 2047, 4);
      stall_asks <= stall_asks + 1;
      run_random(30);

      wait_for_results();
      write_registers(8, MAX_PACKETS, 10);
      run_random(60);

      wait_for_results();
      if (fail_count == 0 && outstanding == 0) begin
         $display("selective_repeat_sender_window test passed");
      end else begin
         $display("selective_repeat_sender_window test failed");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/core/srs_pkg.sv
rtl/core/srs_fifo.sv
rtl/core/srs_front.sv
rtl/core/srs_back.sv
rtl/core/selective_repeat_sender_window.sv
test/srs_window_checker.sv
test/tb_selective_repeat_sender_window.sv
